[design/hbd_pkg.sv]
// Shared types and constants for the hunked binary image deframer.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package hbd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_EOF  = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // Parser position: header bytes, data phase, or faulted.
    typedef enum logic [2:0] {
        POS_HDR0  = 3'd0,
        POS_HDR1  = 3'd1,
        POS_HDR2  = 3'd2,
        POS_HDR3  = 3'd3,
        POS_HDR4  = 3'd4,
        POS_DATA  = 3'd5,
        POS_FAULT = 3'd6
    } pos_t;

    // Configuration register file.
    localparam int unsigned PADDR_W = 3;
    localparam logic FMT_HUNKED = 1'b0;
    localparam logic FMT_RAW    = 1'b1;

    // Flag byte of the end-of-file header.
    localparam logic [7:0] END_FLAG = 8'hff;

    // One result beat.
    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic [15:0] hunk_address;
        logic [7:0]  hunk_flag;
    } result_t;

endpackage

`default_nettype wire

[design/hbd_regs.sv]
// APB configuration register file of the deframer: holds the file format.
// Depends on hbd_pkg.
`default_nettype none

module hbd_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hbd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic                             file_format
);

    logic fmt_reg;
    logic fmt_next;
    logic sel_fmt;

    // Register 0 answers wherever the upper address bit is clear; the upper address bit selects beyond it.
    assign sel_fmt = (paddr[hbd_pkg::PADDR_W-1] == 1'b0);

    always_comb
    begin
        fmt_next = fmt_reg;
        if (psel && penable && pwrite && pready && sel_fmt)
        begin
            fmt_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= hbd_pkg::FMT_HUNKED;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    // Read back; unused words read as zero.
    assign prdata      = sel_fmt ? {31'd0, fmt_reg} : 32'd0;
    assign pready      = 1'b1;
    assign file_format = fmt_reg;

endmodule

`default_nettype wire

[design/hbd_parse.sv]
// Header parser of the deframer: hunk state registers and result logic.
// Depends on hbd_pkg.
`default_nettype none

module hbd_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic            file_format,
    input  wire logic [7:0]      in_byte,
    input  wire logic            stream_end,
    output logic                 res_valid,
    output hbd_pkg::result_t     res
);

    hbd_pkg::pos_t pos_reg;
    hbd_pkg::pos_t pos_next;
    logic [7:0]    flag_reg;
    logic [7:0]    flag_next;
    logic [15:0]   remain_reg;
    logic [15:0]   remain_next;
    logic [15:0]   addr_reg;
    logic [15:0]   addr_next;
    logic          take_header;
    hbd_pkg::pos_t hdr_pos;
    hbd_pkg::status_t res_status;
    logic [7:0]    res_byte;

    // Next hunk state and the result of one beat.
    always_comb
    begin
        pos_next    = pos_reg;
        flag_next   = flag_reg;
        remain_next = remain_reg;
        addr_next   = addr_reg;
        res_valid   = 1'b0;
        res_status  = hbd_pkg::ST_DATA;
        res_byte    = 8'd0;
        take_header = 1'b0;
        hdr_pos     = pos_reg;

        if (file_format == hbd_pkg::FMT_RAW)
        begin
            res_valid = 1'b1;
            if (stream_end)
            begin
                res_status = hbd_pkg::ST_EOF;
            end
            else
            begin
                res_byte = in_byte;
            end
        end
        else if (pos_reg == hbd_pkg::POS_FAULT || pos_reg[2:1] == 2'b11 || stream_end)
        begin
            res_valid  = 1'b1;
            res_status = hbd_pkg::ST_ERR;
        end
        else if (pos_reg == hbd_pkg::POS_DATA && remain_reg != 16'd0)
        begin
            remain_next = remain_reg - 16'd1;
            pos_next    = (remain_reg == 16'd1) ? hbd_pkg::POS_HDR0 : hbd_pkg::POS_DATA;
            res_valid   = 1'b1;
            res_byte    = in_byte;
        end
        else
        begin
            // A data phase with nothing left restarts at header byte 0.
            take_header = 1'b1;
            if (pos_reg == hbd_pkg::POS_DATA)
            begin
                hdr_pos = hbd_pkg::POS_HDR0;
            end
        end

        if (take_header)
        begin
            case (hdr_pos)
                hbd_pkg::POS_HDR0:
                begin
                    flag_next = in_byte;
                    pos_next  = hbd_pkg::POS_HDR1;
                end
                hbd_pkg::POS_HDR1:
                begin
                    remain_next = {in_byte, remain_reg[7:0]};
                    pos_next    = hbd_pkg::POS_HDR2;
                end
                hbd_pkg::POS_HDR2:
                begin
                    remain_next = {remain_reg[15:8], in_byte};
                    pos_next    = hbd_pkg::POS_HDR3;
                end
                hbd_pkg::POS_HDR3:
                begin
                    addr_next = {in_byte, addr_reg[7:0]};
                    pos_next  = hbd_pkg::POS_HDR4;
                end
                default:
                begin
                    // Last header byte: the hunk is complete.
                    addr_next = {addr_reg[15:8], in_byte};
                    if (flag_reg == hbd_pkg::END_FLAG)
                    begin
                        res_valid = 1'b1;
                        if (remain_reg == 16'd0)
                        begin
                            res_status = hbd_pkg::ST_EOF;
                            pos_next   = hbd_pkg::POS_HDR0;
                        end
                        else
                        begin
                            res_status = hbd_pkg::ST_ERR;
                            pos_next   = hbd_pkg::POS_FAULT;
                        end
                    end
                    else
                    begin
                        pos_next = (remain_reg == 16'd0) ? hbd_pkg::POS_HDR0
                                                         : hbd_pkg::POS_DATA;
                    end
                end
            endcase
        end
    end

    // The result carries the hunk state as it stands after the beat.
    always_comb
    begin
        res.status       = res_status;
        res.data_byte    = res_byte;
        res.hunk_address = addr_next;
        res.hunk_flag    = flag_next;
    end

    // Hunk state updates only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= hbd_pkg::POS_HDR0;
            flag_reg   <= 8'd0;
            remain_reg <= 16'd0;
            addr_reg   <= 16'd0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            flag_reg   <= flag_next;
            remain_reg <= remain_next;
            addr_reg   <= addr_next;
        end
    end

endmodule

`default_nettype wire

[design/hbd_outreg.sv]
// Result register of the deframer: holds one beat until the sink takes it.
// Depends on hbd_pkg.
`default_nettype none

module hbd_outreg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             res_valid,
    input  wire hbd_pkg::result_t res,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output hbd_pkg::result_t      out_res,
    output logic                  busy
);

    logic             valid_reg;
    logic             valid_next;
    hbd_pkg::result_t res_reg;

    // Busy while a beat is held and the sink stalls it.
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[design/hunk_binary_deframer_core.sv]
// Hunked binary image deframer, top level.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; input stalls only while a result beat
// is held in the output register and the sink stalls it.
// Reset clears the hunk state, the output valid and the file format (hunked).
// Depends on hbd_pkg, hbd_regs, hbd_parse and hbd_outreg.
`default_nettype none

module hunk_binary_deframer_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hbd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // Input byte stream.
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        stream_end,
    // Result stream.
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [1:0]                  status,
    output logic      [7:0]                  data_byte,
    output logic      [15:0]                 hunk_address,
    output logic      [7:0]                  hunk_flag
);

    logic             file_format;
    logic             accept;
    logic             busy;
    logic             res_valid;
    hbd_pkg::result_t res;
    hbd_pkg::result_t out_res;

    hbd_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .file_format (file_format)
    );

    // A beat is taken whenever the result register can take its result.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    hbd_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .file_format (file_format),
        .in_byte     (in_byte),
        .stream_end  (stream_end),
        .res_valid   (res_valid),
        .res         (res)
    );

    hbd_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .busy      (busy)
    );

    assign status       = out_res.status;
    assign data_byte    = out_res.data_byte;
    assign hunk_address = out_res.hunk_address;
    assign hunk_flag    = out_res.hunk_flag;

endmodule

`default_nettype wire

[tb/tb_hunk_binary_deframer_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hunk_binary_deframer_core: hunked and raw byte streams.
// Depends on hbd_pkg and on the deframer RTL only.

module tb_hunk_binary_deframer_core;

    // One beat of the input byte stream.
    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } stream_beat_t;

    localparam logic [hbd_pkg::PADDR_W-1:0] ADDR_FILE_FORMAT = '0;
    localparam int IDLE_LIMIT = 1000;
    localparam int ITEM_TARGET = 1700;
    localparam int REPORT_LIMIT = 10;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [hbd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   in_byte = '0;
    logic                         stream_end = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [1:0]                   status;
    logic [7:0]                   data_byte;
    logic [15:0]                  hunk_address;
    logic [15:0]                  hunk_address_w;
    logic [7:0]                   hunk_flag;

    // Beats waiting to be driven, the continuing hunked stream, and due results.
    stream_beat_t      pending_beats[$];
    stream_beat_t      hunk_stream[$];
    hbd_pkg::result_t  due_results[$];

    // Deframer state as predicted by the testbench.
    logic        fmt_raw = 1'b0;
    logic [2:0]  hdr_pos = hbd_pkg::POS_HDR0;
    logic [7:0]  cur_flag = '0;
    logic [15:0] remaining = '0;
    logic [15:0] load_addr = '0;

    int mismatches = 0;
    int items_queued = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;
    int run_left = 0;
    bit run_stalled = 1'b0;
    stream_beat_t next_beat;
    hbd_pkg::result_t predicted;
    hbd_pkg::result_t oldest;

    hunk_binary_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .data_byte    (data_byte),
        .hunk_address (hunk_address),
        .hunk_flag    (hunk_flag)
    );

    assign hunk_address_w = hunk_address;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advances the predicted state by one input beat; returns 1 when a result is due.
    function automatic bit deframe_step(input logic [7:0] b, input logic eos,
                                        output hbd_pkg::result_t res);
        bit               hit;
        hbd_pkg::status_t st;
        logic [7:0]       db;
        hit = 1'b1;
        st = hbd_pkg::ST_ERR;
        db = 8'h00;
        if (fmt_raw)
        begin
            st = eos ? hbd_pkg::ST_EOF : hbd_pkg::ST_DATA;
            db = eos ? 8'h00 : b;
        end
        else if (hdr_pos >= hbd_pkg::POS_FAULT || eos)
        begin
            // Faulted, or the source ran dry: error with no state change.
            st = hbd_pkg::ST_ERR;
        end
        else if (hdr_pos == hbd_pkg::POS_DATA && remaining != 0)
        begin
            remaining = remaining - 16'd1;
            if (remaining == 0)
                hdr_pos = hbd_pkg::POS_HDR0;
            st = hbd_pkg::ST_DATA;
            db = b;
        end
        else
        begin
            // A data phase with nothing left falls back to the first header byte.
            if (hdr_pos == hbd_pkg::POS_DATA)
                hdr_pos = hbd_pkg::POS_HDR0;
            hit = 1'b0;
            case (hdr_pos)
                hbd_pkg::POS_HDR0:
                begin
                    cur_flag = b;
                    hdr_pos = hbd_pkg::POS_HDR1;
                end
                hbd_pkg::POS_HDR1:
                begin
                    remaining[15:8] = b;
                    hdr_pos = hbd_pkg::POS_HDR2;
                end
                hbd_pkg::POS_HDR2:
                begin
                    remaining[7:0] = b;
                    hdr_pos = hbd_pkg::POS_HDR3;
                end
                hbd_pkg::POS_HDR3:
                begin
                    load_addr[15:8] = b;
                    hdr_pos = hbd_pkg::POS_HDR4;
                end
                default:
                begin
                    load_addr[7:0] = b;
                    if (cur_flag == hbd_pkg::END_FLAG)
                    begin
                        // End-of-file header when empty, otherwise a fatal error.
                        hit = 1'b1;
                        st = (remaining == 0) ? hbd_pkg::ST_EOF : hbd_pkg::ST_ERR;
                        hdr_pos = (remaining == 0) ? hbd_pkg::POS_HDR0 : hbd_pkg::POS_FAULT;
                    end
                    else
                    begin
                        hdr_pos = (remaining == 0) ? hbd_pkg::POS_HDR0 : hbd_pkg::POS_DATA;
                    end
                end
            endcase
        end
        res = '{st, db, load_addr, cur_flag};
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
    endtask

    // Driver: presents queued beats in bursts and predicts each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= '0;
            stream_end <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (deframe_step(in_byte, stream_end, predicted))
                    due_results.push_back(predicted);
            end
            if (in_valid && in_stall)
            begin
                // Hold the stalled beat unchanged.
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat = pending_beats.pop_front();
                in_byte <= next_beat.value;
                stream_end <= next_beat.eos;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result beat and drives the sink stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with none due: status %0d data 0x%0h",
                                              status, data_byte));
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("status", 16'(oldest.status), 16'(status));
                    check_field("data_byte", 16'(oldest.data_byte), 16'(data_byte));
                    check_field("hunk_address", oldest.hunk_address, hunk_address_w);
                    check_field("hunk_flag", 16'(oldest.hunk_flag), 16'(hunk_flag));
                end
            end
            // The stall pattern changes character whenever the stall timer wraps.
            stall_timer++;
            if (stall_timer == 150)
            begin
                stall_timer = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= (stall_timer % 3 == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_stalled = !run_stalled;
                        run_left = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 20);
                    end
                    else
                    begin
                        run_left--;
                    end
                    out_stall <= run_stalled;
                end
            endcase
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic eos);
        pending_beats.push_back('{b, eos});
        items_queued++;
    endtask

    task automatic push_header(input logic [7:0] flag, input logic [15:0] size,
                               input logic [15:0] addr);
        push_beat(flag, 1'b0);
        push_beat(size[15:8], 1'b0);
        push_beat(size[7:0], 1'b0);
        push_beat(addr[15:8], 1'b0);
        push_beat(addr[7:0], 1'b0);
    endtask

    // Appends one piece to the hunked stream: a hunk (now and then with a stream end in
    // its data), an end-of-file header, or a stray stream end.
    task automatic gen_hunk();
        int          r;
        logic [7:0]  flag;
        logic [15:0] size;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 16'hffff));
        if (r < 12)
        begin
            hunk_stream.push_back('{8'($urandom_range(0, 255)), 1'b1});
            return;
        end
        if (r < 20)
        begin
            flag = hbd_pkg::END_FLAG;
            size = 16'd0;
        end
        else
        begin
            flag = 8'($urandom_range(0, 254));
            r = $urandom_range(0, 99);
            if (r < 10)
                size = 16'd0;
            else if (r < 80)
                size = 16'($urandom_range(1, 16));
            else if (r < 95)
                size = 16'($urandom_range(17, 64));
            else
                size = 16'($urandom_range(65, 400));
        end
        hunk_stream.push_back('{flag, 1'b0});
        hunk_stream.push_back('{size[15:8], 1'b0});
        hunk_stream.push_back('{size[7:0], 1'b0});
        hunk_stream.push_back('{addr[15:8], 1'b0});
        hunk_stream.push_back('{addr[7:0], 1'b0});
        for (int i = 0; i < size; i++)
        begin
            // Now and then the source runs dry in the middle of the data.
            if ($urandom_range(0, 99) < 3)
                hunk_stream.push_back('{8'($urandom_range(0, 255)), 1'b1});
            hunk_stream.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
    endtask

    // Moves the next n beats of the hunked stream to the driver.
    task automatic queue_hunked(input int n);
        stream_beat_t sb;
        while (hunk_stream.size() < n)
            gen_hunk();
        repeat (n)
        begin
            sb = hunk_stream.pop_front();
            push_beat(sb.value, sb.eos);
        end
    endtask

    // Waits until every beat is driven and every result has arrived.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Writes the file format register through the configuration port while idle.
    task automatic set_format(input logic fmt);
        drain();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FILE_FORMAT;
        pwdata <= {31'd0, fmt};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fmt_raw = fmt;
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_format(hbd_pkg::FMT_HUNKED);

        // Directed: field extremes, zero-size hunk, stream end mid-header, end of file, then raw beats.
        push_header(8'h00, 16'h0002, 16'h0000);
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b0);
        push_header(8'hfe, 16'h0000, 16'hffff);
        push_beat(8'h12, 1'b0);
        push_beat(8'hff, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'h01, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(8'h01, 1'b0);
        push_beat(8'h5a, 1'b0);
        push_header(hbd_pkg::END_FLAG, 16'h0000, 16'h1234);
        set_format(hbd_pkg::FMT_RAW);
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b0);
        push_beat(8'h3c, 1'b1);
        push_beat(8'ha5, 1'b0);

        // Random phases; hunked phases resume the stream where the last one stopped.
        while (items_queued < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                set_format(hbd_pkg::FMT_HUNKED);
                queue_hunked($urandom_range(20, 160));
            end
            else
            begin
                set_format(hbd_pkg::FMT_RAW);
                n = $urandom_range(10, 60);
                repeat (n)
                    push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
        end

        // Finish the open hunk, then fault on an end flag with a nonzero size.
        set_format(hbd_pkg::FMT_HUNKED);
        queue_hunked(hunk_stream.size());
        push_header(hbd_pkg::END_FLAG, 16'hffff, 16'hffff);
        push_beat(8'h00, 1'b0);
        push_beat(8'h7f, 1'b1);
        push_beat(8'h81, 1'b0);
        set_format(hbd_pkg::FMT_RAW);
        push_beat(8'h55, 1'b0);
        push_beat(8'haa, 1'b1);
        set_format(hbd_pkg::FMT_HUNKED);
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b0);

        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
design/hbd_pkg.sv
design/hbd_regs.sv
design/hbd_parse.sv
design/hbd_outreg.sv
design/hunk_binary_deframer_core.sv
tb/tb_hunk_binary_deframer_core.sv
